// ===== sv/rssp_pkg.sv =====
// shared types and constants for the raptor source symbol placement block
package rssp_pkg;

  // default sizing
  localparam int unsigned MaxSourceBlocks    = 16;
  localparam int unsigned MaxSubBlocks       = 16;
  localparam int unsigned MaxSymbolsPerBlock = 1024;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TRANSFER_LENGTH    = 3'd0,
    REG_SYMBOL_SIZE        = 3'd1,
    REG_SOURCE_BLOCK_COUNT = 3'd2,
    REG_SUB_BLOCK_COUNT    = 3'd3,
    REG_SYMBOL_ALIGNMENT   = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_PLACED    = 2'd0,
    ST_REPAIR    = 2'd1,
    ST_RANGE     = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] block_number;
    logic [15:0] symbol_id;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  sub_block_index;
    logic [31:0] buffer_offset;
    logic [15:0] payload_offset;
    logic [15:0] length;
    logic        block_complete;
    logic        file_complete;
    logic        last;
  } out_item_t;

  // derived partition handed to the item sequencer
  typedef struct packed {
    logic        ready;
    logic [4:0]  z;
    logic [4:0]  zl;
    logic [31:0] kl;
    logic [31:0] ks;
    logic [4:0]  n;
    logic [4:0]  nl;
    logic [15:0] len_l;
    logic [15:0] len_s;
    logic [31:0] klt;
    logic [31:0] kst;
    logic [31:0] zlklt;
  } part_t;

  typedef enum logic [2:0] {
    D_IDLE, D_KT, D_KS, D_UNITS, D_TS, D_MUL0, D_MUL1, D_MUL2
  } derive_state_e;

  typedef enum logic [2:0] {
    I_IDLE, I_CHK, I_BASE, I_EMIT
  } item_state_e;

endpackage

// ===== sv/rssp_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module rssp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        busy_o,
  output logic [32:0] quo_o,
  output logic [15:0] rem_o
);

  logic [32:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] dsr_q;
  logic [5:0]  cnt_q;
  logic [16:0] trial;
  logic        ge;

  // one shift-subtract step
  always_comb begin
    trial = {rem_q, quo_q[32]};
    ge    = trial >= {1'b0, dsr_q};
    rem_d = ge ? 16'(trial - {1'b0, dsr_q}) : trial[15:0];
    quo_d = {quo_q[31:0], ge};
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= 6'd33;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/rssp_part.sv =====
// configuration registers and partition derivation sequencer
module rssp_part #(
  parameter int unsigned MAX_SOURCE_BLOCKS = rssp_pkg::MaxSourceBlocks,
  parameter int unsigned MAX_SUB_BLOCKS    = rssp_pkg::MaxSubBlocks
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rssp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rssp_pkg::CfgDataW-1:0] cfg_wdata_i,
  output rssp_pkg::part_t               part_o
);

  localparam int unsigned NMax = (MAX_SUB_BLOCKS < 16) ? MAX_SUB_BLOCKS : 16;

  logic [31:0] f_q;
  logic [15:0] t_q;
  logic [4:0]  zc_q, nc_q;
  logic [7:0]  al_q;

  logic [15:0] t_eff;
  logic [7:0]  al_eff;
  logic [4:0]  z_eff, n_eff, z_raw, n_raw;

  rssp_pkg::derive_state_e state_q, state_d;
  logic        kick_q, kick_d;
  logic        advance;

  logic [32:0] div_dvd;
  logic [15:0] div_dsr;
  logic        div_busy;
  logic [32:0] div_quo;
  logic [15:0] div_rem;

  logic [31:0] kt_q, kl_q, ks_q, klt_q, kst_q, zlklt_q;
  logic [4:0]  zl_q, nl_q;
  logic [15:0] units_q, tl_q, ts_q, tp_q, len_l_q, len_s_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q  <= 32'd1;
      t_q  <= 16'd4;
      zc_q <= 5'd1;
      nc_q <= 5'd1;
      al_q <= 8'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rssp_pkg::REG_TRANSFER_LENGTH:    f_q  <= cfg_wdata_i;
        rssp_pkg::REG_SYMBOL_SIZE:        t_q  <= cfg_wdata_i[15:0];
        rssp_pkg::REG_SOURCE_BLOCK_COUNT: zc_q <= cfg_wdata_i[4:0];
        rssp_pkg::REG_SUB_BLOCK_COUNT:    nc_q <= cfg_wdata_i[4:0];
        rssp_pkg::REG_SYMBOL_ALIGNMENT:   al_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // zero and oversize register values
  always_comb begin
    t_eff  = (t_q == '0) ? 16'd1 : t_q;
    al_eff = (al_q == '0) ? 8'd1 : al_q;
    z_raw  = (zc_q == '0) ? 5'd1 : zc_q;
    n_raw  = (nc_q == '0) ? 5'd1 : nc_q;
    z_eff  = (32'(z_raw) > MAX_SOURCE_BLOCKS) ? 5'(MAX_SOURCE_BLOCKS) : z_raw;
    n_eff  = (32'(n_raw) > NMax) ? 5'(NMax) : n_raw;
  end

  rssp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (kick_q),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign advance = !kick_q && !div_busy;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rssp_pkg::D_IDLE:  state_d = rssp_pkg::D_IDLE;
      rssp_pkg::D_KT:    if (advance) state_d = rssp_pkg::D_KS;
      rssp_pkg::D_KS:    if (advance) state_d = rssp_pkg::D_UNITS;
      rssp_pkg::D_UNITS: if (advance) state_d = rssp_pkg::D_TS;
      rssp_pkg::D_TS:    if (advance) state_d = rssp_pkg::D_MUL0;
      rssp_pkg::D_MUL0:  state_d = rssp_pkg::D_MUL1;
      rssp_pkg::D_MUL1:  state_d = rssp_pkg::D_MUL2;
      rssp_pkg::D_MUL2:  state_d = rssp_pkg::D_IDLE;
      default:           state_d = rssp_pkg::D_IDLE;
    endcase
    if (cfg_we_i) state_d = rssp_pkg::D_KT;
  end

  // divider operands and start pulse
  always_comb begin
    div_dvd = '0;
    div_dsr = 16'd1;
    unique case (state_q)
      rssp_pkg::D_KT: begin
        div_dvd = {1'b0, f_q} + {17'b0, t_eff} - 33'd1;
        div_dsr = t_eff;
      end
      rssp_pkg::D_KS: begin
        div_dvd = {1'b0, kt_q};
        div_dsr = {11'b0, z_eff};
      end
      rssp_pkg::D_UNITS: begin
        div_dvd = {17'b0, t_eff};
        div_dsr = {8'b0, al_eff};
      end
      rssp_pkg::D_TS: begin
        div_dvd = {17'b0, units_q};
        div_dsr = {11'b0, n_eff};
      end
      default: ;
    endcase
    kick_d = cfg_we_i ||
             ((state_d != state_q) &&
              (state_d == rssp_pkg::D_KS || state_d == rssp_pkg::D_UNITS ||
               state_d == rssp_pkg::D_TS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rssp_pkg::D_KT;
      kick_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      kick_q  <= kick_d;
    end
  end

  // capture quotients and products
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      rssp_pkg::D_KT: if (advance) kt_q <= div_quo[31:0];
      rssp_pkg::D_KS: if (advance) begin
        ks_q <= div_quo[31:0];
        kl_q <= div_quo[31:0] + {31'b0, div_rem != '0};
        zl_q <= div_rem[4:0];
      end
      rssp_pkg::D_UNITS: if (advance) units_q <= div_quo[15:0];
      rssp_pkg::D_TS: if (advance) begin
        ts_q <= div_quo[15:0];
        tl_q <= div_quo[15:0] + {15'b0, div_rem != '0};
        nl_q <= div_rem[4:0];
      end
      rssp_pkg::D_MUL0: begin
        tp_q    <= 16'(units_q * al_eff);
        len_l_q <= 16'(tl_q * al_eff);
        len_s_q <= 16'(ts_q * al_eff);
      end
      rssp_pkg::D_MUL1: begin
        klt_q <= 32'(kl_q * tp_q);
        kst_q <= 32'(ks_q * tp_q);
      end
      rssp_pkg::D_MUL2: zlklt_q <= 32'(zl_q * klt_q);
      default: ;
    endcase
  end

  always_comb begin
    part_o.ready = state_q == rssp_pkg::D_IDLE;
    part_o.z     = z_eff;
    part_o.zl    = zl_q;
    part_o.kl    = kl_q;
    part_o.ks    = ks_q;
    part_o.n     = n_eff;
    part_o.nl    = nl_q;
    part_o.len_l = len_l_q;
    part_o.len_s = len_s_q;
    part_o.klt   = klt_q;
    part_o.kst   = kst_q;
    part_o.zlklt = zlklt_q;
  end

endmodule

// ===== sv/rssp_store.sv =====
// received flag memory and per-block count memory with clearing pass
module rssp_store #(
  parameter int unsigned MAX_SOURCE_BLOCKS     = rssp_pkg::MaxSourceBlocks,
  parameter int unsigned MAX_SYMBOLS_PER_BLOCK = rssp_pkg::MaxSymbolsPerBlock,
  localparam int unsigned FlagDepth = MAX_SOURCE_BLOCKS * MAX_SYMBOLS_PER_BLOCK,
  localparam int unsigned FlagAw    = (FlagDepth > 1) ? $clog2(FlagDepth) : 1,
  localparam int unsigned Bw        = (MAX_SOURCE_BLOCKS > 1) ? $clog2(MAX_SOURCE_BLOCKS) : 1,
  localparam int unsigned Cw        = $clog2(MAX_SYMBOLS_PER_BLOCK + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [FlagAw-1:0] flag_raddr_i,
  input  logic [Bw-1:0]     cnt_raddr_i,
  input  logic              flag_we_i,
  input  logic [FlagAw-1:0] flag_waddr_i,
  input  logic              cnt_we_i,
  input  logic [Bw-1:0]     cnt_waddr_i,
  input  logic [Cw-1:0]     cnt_wdata_i,
  output logic              flag_rdata_o,
  output logic [Cw-1:0]     cnt_rdata_o,
  output logic              busy_o
);

  logic          flag_mem [FlagDepth];
  logic [Cw-1:0] cnt_mem  [MAX_SOURCE_BLOCKS];
  logic [FlagAw:0] clr_q;
  logic          clearing;

  assign clearing = 32'(clr_q) < FlagDepth;
  assign busy_o   = clearing;

  // clearing pass after reset, one entry a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clearing) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // flag memory
  always_ff @(posedge clk_i) begin
    if (clearing) begin
      flag_mem[clr_q[FlagAw-1:0]] <= 1'b0;
    end else if (flag_we_i) begin
      flag_mem[flag_waddr_i] <= 1'b1;
    end
    flag_rdata_o <= flag_mem[flag_raddr_i];
  end

  // count memory
  always_ff @(posedge clk_i) begin
    if (clearing) begin
      if (32'(clr_q) < MAX_SOURCE_BLOCKS) cnt_mem[clr_q[Bw-1:0]] <= '0;
    end else if (cnt_we_i) begin
      cnt_mem[cnt_waddr_i] <= cnt_wdata_i;
    end
    cnt_rdata_o <= cnt_mem[cnt_raddr_i];
  end

endmodule

// ===== sv/raptor_source_symbol_placement.sv =====
// top level: item sequencer for raptor source symbol placement
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_ready_o  | rssp_pkg::in_item_t
//  out     | output    | out_valid_o / out_ready_i| rssp_pkg::out_item_t
//  cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// a placed symbol goes through accept, memory check and base offset, then gives one
// sub-block result a cycle while the output does not stall; a rejected symbol skips base offset.
// after each register write the partition is rederived by a shared one-bit-a-cycle
// divider, with in_ready_o low until the derivation is done.
// after reset a clearing pass sweeps all MAX_SOURCE_BLOCKS * MAX_SYMBOLS_PER_BLOCK
// flag memory entries (16384 by default) before the first symbol.
// the output register lets the next symbol be accepted while a result waits.
module raptor_source_symbol_placement #(
  parameter int unsigned MAX_SOURCE_BLOCKS     = rssp_pkg::MaxSourceBlocks,
  parameter int unsigned MAX_SUB_BLOCKS        = rssp_pkg::MaxSubBlocks,
  parameter int unsigned MAX_SYMBOLS_PER_BLOCK = rssp_pkg::MaxSymbolsPerBlock
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rssp_pkg::in_item_t            in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rssp_pkg::out_item_t           out_o,
  input  logic                          cfg_we_i,
  input  logic [rssp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rssp_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned FlagDepth = MAX_SOURCE_BLOCKS * MAX_SYMBOLS_PER_BLOCK;
  localparam int unsigned FlagAw    = (FlagDepth > 1) ? $clog2(FlagDepth) : 1;
  localparam int unsigned Bw        = (MAX_SOURCE_BLOCKS > 1) ? $clog2(MAX_SOURCE_BLOCKS) : 1;
  localparam int unsigned Cw        = $clog2(MAX_SYMBOLS_PER_BLOCK + 1);

  rssp_pkg::part_t part;
  logic            clr_busy;

  rssp_pkg::item_state_e state_q, state_d;

  logic [15:0] b_q, id_q;
  logic [31:0] raddr_full;
  logic        flag_rd;
  logic [Cw-1:0] cnt_rd;

  // check stage signals
  logic [31:0]     k;
  rssp_pkg::status_e status_c;
  logic            upd;
  logic [Cw-1:0]   cnt_new;
  logic            bc_c, fc_c;
  logic [4:0]      cbc_q, cbc_d;
  logic [4:0]      empties;
  logic            lo_blk;
  logic [Bw-1:0]   bsel;
  logic [31:0]     msel;

  rssp_pkg::status_e status_q;
  logic            bc_q, fc_q;
  logic [31:0]     prod_q, idl_q, ids_q, kll_q, kls_q, base_q, base_d;
  logic [4:0]      s_q, s_d;
  logic [15:0]     poff_q, poff_d;

  logic            out_valid_q, out_valid_d;
  rssp_pkg::out_item_t out_q, out_d;
  logic            slot_free, emit_last, s_large;

  rssp_part #(
    .MAX_SOURCE_BLOCKS (MAX_SOURCE_BLOCKS),
    .MAX_SUB_BLOCKS    (MAX_SUB_BLOCKS)
  ) u_part (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .part_o      (part)
  );

  assign raddr_full = 32'(in_i.block_number) * 32'(MAX_SYMBOLS_PER_BLOCK)
                    + 32'(in_i.symbol_id);

  rssp_store #(
    .MAX_SOURCE_BLOCKS     (MAX_SOURCE_BLOCKS),
    .MAX_SYMBOLS_PER_BLOCK (MAX_SYMBOLS_PER_BLOCK)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .flag_raddr_i (raddr_full[FlagAw-1:0]),
    .cnt_raddr_i  (in_i.block_number[Bw-1:0]),
    .flag_we_i    (state_q == rssp_pkg::I_CHK && upd),
    .flag_waddr_i (FlagAw'(32'(b_q) * 32'(MAX_SYMBOLS_PER_BLOCK) + 32'(id_q))),
    .cnt_we_i     (state_q == rssp_pkg::I_CHK && upd),
    .cnt_waddr_i  (b_q[Bw-1:0]),
    .cnt_wdata_i  (cnt_new),
    .flag_rdata_o (flag_rd),
    .cnt_rdata_o  (cnt_rd),
    .busy_o       (clr_busy)
  );

  assign in_ready_o = state_q == rssp_pkg::I_IDLE && part.ready && !clr_busy;

  // symbol checks against the partition and stored counts
  always_comb begin
    lo_blk  = b_q < 16'(part.zl);
    k       = lo_blk ? part.kl : part.ks;
    if (b_q >= 16'(part.z)) begin
      status_c = rssp_pkg::ST_RANGE;
    end else if (k > 32'(MAX_SYMBOLS_PER_BLOCK)) begin
      status_c = rssp_pkg::ST_TOO_LARGE;
    end else if (32'(id_q) >= k) begin
      status_c = rssp_pkg::ST_REPAIR;
    end else begin
      status_c = rssp_pkg::ST_PLACED;
    end
    upd     = status_c == rssp_pkg::ST_PLACED && !flag_rd;
    cnt_new = cnt_rd + Cw'(upd);
    bc_c    = (status_c == rssp_pkg::ST_PLACED || status_c == rssp_pkg::ST_REPAIR) &&
              (32'(cnt_new) >= k);
    cbc_d   = cbc_q;
    if (upd && 32'(cnt_new) == k && cbc_q != 5'd31) cbc_d = cbc_q + 5'd1;
    empties = (part.ks == '0) ? (part.z - part.zl) : 5'd0;
    fc_c    = ({1'b0, cbc_d} + {1'b0, empties}) >= {1'b0, part.z};
    bsel    = lo_blk ? b_q[Bw-1:0] : Bw'(b_q - 16'(part.zl));
    msel    = lo_blk ? part.klt : part.kst;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rssp_pkg::I_IDLE: if (in_valid_i && in_ready_o) state_d = rssp_pkg::I_CHK;
      rssp_pkg::I_CHK:  state_d = (status_c == rssp_pkg::ST_PLACED) ? rssp_pkg::I_BASE
                                                                  : rssp_pkg::I_EMIT;
      rssp_pkg::I_BASE: state_d = rssp_pkg::I_EMIT;
      rssp_pkg::I_EMIT: if (slot_free && emit_last) state_d = rssp_pkg::I_IDLE;
      default:          state_d = rssp_pkg::I_IDLE;
    endcase
  end

  // result generation
  always_comb begin
    slot_free   = !out_valid_q || out_ready_i;
    s_large     = s_q < part.nl;
    emit_last   = (status_q != rssp_pkg::ST_PLACED) || (s_q + 5'd1 == part.n);
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    base_d      = base_q;
    s_d         = s_q;
    poff_d      = poff_q;
    if (state_q == rssp_pkg::I_BASE) begin
      base_d = lo_blk ? prod_q : part.zlklt + prod_q;
      s_d    = '0;
      poff_d = '0;
    end
    if (state_q == rssp_pkg::I_EMIT && slot_free) begin
      out_valid_d           = 1'b1;
      out_d.status          = status_q;
      out_d.block_complete  = bc_q;
      out_d.file_complete   = fc_q;
      out_d.last            = emit_last;
      if (status_q == rssp_pkg::ST_PLACED) begin
        out_d.sub_block_index = s_q[3:0];
        out_d.length          = s_large ? part.len_l : part.len_s;
        out_d.buffer_offset   = base_q + (s_large ? idl_q : ids_q);
        out_d.payload_offset  = poff_q;
        base_d = base_q + (s_large ? kll_q : kls_q);
        poff_d = poff_q + (s_large ? part.len_l : part.len_s);
        s_d    = s_q + 5'd1;
      end else begin
        out_d.sub_block_index = '0;
        out_d.length          = '0;
        out_d.buffer_offset   = '0;
        out_d.payload_offset  = '0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rssp_pkg::I_IDLE;
      out_valid_q <= 1'b0;
      cbc_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == rssp_pkg::I_CHK) cbc_q <= cbc_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      b_q  <= in_i.block_number;
      id_q <= in_i.symbol_id;
    end
    if (state_q == rssp_pkg::I_CHK) begin
      status_q <= status_c;
      bc_q     <= bc_c;
      fc_q     <= fc_c;
      prod_q   <= 32'(bsel * msel);
      idl_q    <= 32'(id_q) * 32'(part.len_l);
      ids_q    <= 32'(id_q) * 32'(part.len_s);
      kll_q    <= 32'(k[Cw-1:0]) * 32'(part.len_l);
      kls_q    <= 32'(k[Cw-1:0]) * 32'(part.len_s);
    end
    base_q <= base_d;
    s_q    <= s_d;
    poff_q <= poff_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // an accepted symbol always goes to the memory check next
  a_accept_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == rssp_pkg::I_CHK)
    else $error("accepted symbol not checked");

  // no symbol taken during clearing or derivation
  a_ready_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> part.ready && !clr_busy)
    else $error("symbol taken while busy");

  // a rejected symbol yields a single final result
  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != rssp_pkg::ST_PLACED |-> out_o.last)
    else $error("rejected result not marked last");

  // a rejected symbol carries no placement
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != rssp_pkg::ST_PLACED |->
      out_o.length == '0 && out_o.buffer_offset == '0)
    else $error("rejected result has placement");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the raptor source symbol placement block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 100000;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned FlagDepth =
    rssp_pkg::MaxSourceBlocks * rssp_pkg::MaxSymbolsPerBlock;

  // directed rows, typed result only where it is plain to see
  typedef struct packed {
    logic [15:0]         blk;
    logic [15:0]         sid;
    logic                typed;
    rssp_pkg::out_item_t res;
  } dir_row_t;

  localparam int unsigned DirRows = 9;
  localparam dir_row_t DirTab [DirRows] = '{
    '{16'd0, 16'd1, 1'b1,
      '{rssp_pkg::ST_REPAIR, 4'd0, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1}},
    '{16'hFFFF, 16'hFFFF, 1'b1,
      '{rssp_pkg::ST_RANGE, 4'd0, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1}},
    '{16'd0, 16'd0, 1'b1,
      '{rssp_pkg::ST_PLACED, 4'd0, 32'd0, 16'd0, 16'd4, 1'b1, 1'b1, 1'b1}},
    '{16'd0, 16'd0, 1'b1,
      '{rssp_pkg::ST_PLACED, 4'd0, 32'd0, 16'd0, 16'd4, 1'b1, 1'b1, 1'b1}},
    '{16'd1, 16'd0, 1'b1,
      '{rssp_pkg::ST_RANGE, 4'd0, 32'd0, 16'd0, 16'd0, 1'b0, 1'b1, 1'b1}},
    '{16'hAAAA, 16'h5555, 1'b0, '0},
    '{16'h5555, 16'hAAAA, 1'b0, '0},
    '{16'd0, 16'hFFFF, 1'b0, '0},
    '{16'd0, 16'h8000, 1'b0, '0}
  };

  typedef struct {
    longint unsigned kl, ks, zl, z, tl, ts, nl, n, al, tp;
  } partition_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  rssp_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  rssp_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [rssp_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [rssp_pkg::CfgDataW-1:0] cfg_wdata = '0;

  // shadow of the block's registers and state
  logic [31:0] sh_len;
  logic [15:0] sh_sym;
  logic [4:0]  sh_blocks;
  logic [4:0]  sh_subs;
  logic [7:0]  sh_align;
  bit          rx_flag [FlagDepth];
  int unsigned rx_count [rssp_pkg::MaxSourceBlocks];
  int unsigned done_blocks;

  rssp_pkg::out_item_t pending_results [$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned cyc = 0;

  raptor_source_symbol_placement uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic partition_t derive_partition();
    partition_t p;
    longint unsigned t, kt, units;
    t = (sh_sym == 0) ? 1 : sh_sym;
    p.al = (sh_align == 0) ? 1 : sh_align;
    p.z = (sh_blocks == 0) ? 1 : sh_blocks;
    p.n = (sh_subs == 0) ? 1 : sh_subs;
    if (p.z > rssp_pkg::MaxSourceBlocks) p.z = rssp_pkg::MaxSourceBlocks;
    if (p.n > rssp_pkg::MaxSubBlocks) p.n = rssp_pkg::MaxSubBlocks;
    if (p.n > 16) p.n = 16;
    kt = (longint'(sh_len) + t - 1) / t;
    p.ks = kt / p.z;
    p.kl = (kt + p.z - 1) / p.z;
    p.zl = kt - p.ks * p.z;
    units = t / p.al;
    p.ts = units / p.n;
    p.tl = (units + p.n - 1) / p.n;
    p.nl = units - p.ts * p.n;
    p.tp = units * p.al;
    return p;
  endfunction

  function automatic bit file_done(partition_t p);
    longint unsigned empties;
    empties = (p.ks == 0) ? (p.z - p.zl) : 0;
    return (done_blocks + empties) >= p.z;
  endfunction

  // queue one expected output transaction
  function automatic void expect_result(rssp_pkg::out_item_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic rssp_pkg::out_item_t reject(rssp_pkg::status_e st, bit bc, bit fc);
    rssp_pkg::out_item_t r;
    r = '0;
    r.status = st;
    r.block_complete = bc;
    r.file_complete = fc;
    r.last = 1'b1;
    return r;
  endfunction

  // work out the placements a symbol causes and update the shadow state
  function automatic void place_symbol(rssp_pkg::in_item_t it);
    partition_t p;
    longint unsigned b, id, k, base, poff, len;
    int unsigned fi;
    bit bc, fc;
    rssp_pkg::out_item_t r;
    p = derive_partition();
    b = it.block_number;
    id = it.symbol_id;
    if (b >= p.z) begin
      expect_result(reject(rssp_pkg::ST_RANGE, 1'b0, file_done(p)));
      return;
    end
    k = (b < p.zl) ? p.kl : p.ks;
    if (k > rssp_pkg::MaxSymbolsPerBlock) begin
      expect_result(reject(rssp_pkg::ST_TOO_LARGE, 1'b0, file_done(p)));
      return;
    end
    if (id >= k) begin
      expect_result(reject(rssp_pkg::ST_REPAIR, rx_count[b] >= k, file_done(p)));
      return;
    end
    fi = b * rssp_pkg::MaxSymbolsPerBlock + id;
    if (!rx_flag[fi]) begin
      rx_flag[fi] = 1'b1;
      if (rx_count[b] < 16'hFFFF) rx_count[b]++;
      if (rx_count[b] == k && done_blocks < 31) done_blocks++;
    end
    bc = rx_count[b] >= k;
    fc = file_done(p);
    if (b < p.zl) base = b * p.kl * p.tp;
    else base = p.zl * p.kl * p.tp + (b - p.zl) * p.ks * p.tp;
    poff = 0;
    for (longint unsigned s = 0; s < p.n; s++) begin
      len = ((s < p.nl) ? p.tl : p.ts) * p.al;
      r.status = rssp_pkg::ST_PLACED;
      r.sub_block_index = s[3:0];
      r.buffer_offset = 32'(base + id * len);
      r.payload_offset = 16'(poff);
      r.length = 16'(len);
      r.block_complete = bc;
      r.file_complete = fc;
      r.last = (s + 1 == p.n);
      expect_result(r);
      base += k * len;
      poff += len;
    end
  endfunction

  // one input transaction, sender idles between bursts
  task automatic send_symbol(rssp_pkg::in_item_t it);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (!in_ready);
    place_symbol(it);
    burst_left--;
  endtask

  // write all registers once the block has drained
  task automatic write_regs(logic [31:0] f, logic [15:0] t, logic [4:0] z,
                            logic [4:0] n, logic [7:0] al);
    rssp_pkg::cfg_reg_e idx;
    logic [31:0] val;
    in_valid <= 1'b0;
    burst_left = 0;
    wait (pending_results.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    for (int i = 0; i < 5; i++) begin
      idx = rssp_pkg::cfg_reg_e'(i);
      case (idx)
        rssp_pkg::REG_TRANSFER_LENGTH: val = f;
        rssp_pkg::REG_SYMBOL_SIZE: val = {16'd0, t};
        rssp_pkg::REG_SOURCE_BLOCK_COUNT: val = {27'd0, z};
        rssp_pkg::REG_SUB_BLOCK_COUNT: val = {27'd0, n};
        default: val = {24'd0, al};
      endcase
      cfg_we <= 1'b1;
      cfg_idx <= idx;
      cfg_wdata <= val;
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    sh_len = f;
    sh_sym = t;
    sh_blocks = z;
    sh_subs = n;
    sh_align = al;
  endtask

  // random symbols, mostly source symbols of existing blocks
  task automatic random_symbols(int unsigned count);
    partition_t p;
    rssp_pkg::in_item_t it;
    int unsigned pick;
    longint unsigned k;
    for (int unsigned i = 0; i < count; i++) begin
      p = derive_partition();
      pick = $urandom_range(0, 9);
      it.block_number = 16'($urandom_range(0, int'(p.z) - 1));
      k = (it.block_number < p.zl) ? p.kl : p.ks;
      if (pick == 0) it.block_number = 16'($urandom);
      if (pick == 1 || k == 0) it.symbol_id = 16'($urandom);
      else if (pick == 2) it.symbol_id = 16'(k + $urandom_range(0, 3));
      else it.symbol_id = 16'($urandom_range(0, int'((k > 1024 ? 1024 : k) - 1)));
      send_symbol(it);
    end
  endtask

  // stimulus
  initial begin
    rssp_pkg::in_item_t it;
    sh_len = 32'd1;
    sh_sym = 16'd4;
    sh_blocks = 5'd1;
    sh_subs = 5'd1;
    sh_align = 8'd4;
    done_blocks = 0;
    foreach (rx_count[i]) rx_count[i] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows on the reset settings
    for (int i = 0; i < DirRows; i++) begin
      it.block_number = DirTab[i].blk;
      it.symbol_id = DirTab[i].sid;
      send_symbol(it);
      if (DirTab[i].typed) begin
        void'(pending_results.pop_back());
        expect_result(DirTab[i].res);
      end
    end

    // phases through several partitions
    write_regs(32'd100000, 16'd64, 5'd16, 5'd16, 8'd4);
    random_symbols(40);
    write_regs(32'hFFFF_FFFF, 16'hFFFF, 5'd16, 5'd1, 8'd255);
    random_symbols(30);
    write_regs(32'd0, 16'd0, 5'd0, 5'd0, 8'd0);
    random_symbols(25);
    write_regs(32'd5000, 16'd10, 5'd31, 5'd31, 8'd3);
    random_symbols(45);
    write_regs(32'd3000, 16'd100, 5'd5, 5'd7, 8'd200);
    random_symbols(30);
    write_regs(32'd2000, 16'd20, 5'd4, 5'd3, 8'd4);
    random_symbols(80);

    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // receiver stalls, with calm stretches
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      cyc <= 0;
    end else begin
      cyc <= cyc + 1;
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (cyc[8]) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left <= $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each output transaction with the oldest expected placement
  always @(posedge clk_i) begin
    rssp_pkg::out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (want.status != out_data.status
            || want.sub_block_index != out_data.sub_block_index
            || want.buffer_offset != out_data.buffer_offset
            || want.payload_offset != out_data.payload_offset
            || want.length != out_data.length
            || want.block_complete != out_data.block_complete
            || want.file_complete != out_data.file_complete
            || want.last != out_data.last) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %p got %p", want, out_data);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
sv/rssp_pkg.sv
sv/rssp_div.sv
sv/rssp_part.sv
sv/rssp_store.sv
sv/raptor_source_symbol_placement.sv
tb/tb_top.sv
